/* sv/bfps_pkg.sv */
// Package for the byte FIFO with peek and skip.
// Holds request/response payload types, operation and status codes, and ring arithmetic.
// No dependencies.
package bfps_pkg;

   localparam int DEPTH = 256;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int KIND_W = 3;
   localparam int BYTE_W = 8;
   localparam int CNT_W = 9;
   localparam int STAT_W = 2;

   localparam logic [KIND_W-1:0] OP_PUSH  = 3'd0;
   localparam logic [KIND_W-1:0] OP_POP   = 3'd1;
   localparam logic [KIND_W-1:0] OP_PEEK  = 3'd2;
   localparam logic [KIND_W-1:0] OP_SKIP  = 3'd3;
   localparam logic [KIND_W-1:0] OP_CLEAR = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);
   localparam logic [CNT_W:0] DEPTH_S = (CNT_W + 1)'(DEPTH);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] push_byte;
      logic [CNT_W-1:0]  count_or_offset;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic [STAT_W-1:0] status;
      logic [OCC_W-1:0]  fill_level;
      logic              not_empty;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } mem_ctrl_type;

   // (pos + n) modulo DEPTH, for pos < DEPTH and n <= DEPTH
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] pos,
                                                 input logic [CNT_W-1:0] n);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(pos) + (CNT_W + 1)'(n);
      if (s >= DEPTH_S) begin
         s = s - DEPTH_S;
      end
      return s[IDX_W-1:0];
   endfunction

endpackage

/* sv/bfps_store.sv */
// Byte storage array of the FIFO: one write port, one registered read port.
// Depends on bfps_pkg.
module bfps_store (
   input  logic                      clock,
   input  bfps_pkg::mem_ctrl_type    mem_ctrl,
   output logic [bfps_pkg::BYTE_W-1:0] rd_q
);

   logic [bfps_pkg::BYTE_W-1:0] mem [bfps_pkg::DEPTH];
   logic [bfps_pkg::BYTE_W-1:0] rd_q_ff;

   always_ff @(posedge clock) begin
      if (mem_ctrl.wr_en) begin
         mem[mem_ctrl.wr_addr] <= mem_ctrl.wr_data;
      end
      if (mem_ctrl.rd_en) begin
         rd_q_ff <= mem[mem_ctrl.rd_addr];
      end
   end

   assign rd_q = rd_q_ff;

endmodule

/* sv/bfps_ctrl.sv */
// FIFO control: decodes each request, updates head, tail and occupancy,
// drives the store ports and registers the response. Depends on bfps_pkg.
module bfps_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  bfps_pkg::req_type           req,
   input  logic [bfps_pkg::BYTE_W-1:0] rd_q,
   output bfps_pkg::mem_ctrl_type      mem_ctrl,
   output logic                        rsp_strobe,
   output bfps_pkg::rsp_type           rsp
);

   logic [bfps_pkg::IDX_W-1:0]  head_ff, head_in;
   logic [bfps_pkg::IDX_W-1:0]  tail_ff, tail_in;
   logic [bfps_pkg::OCC_W-1:0]  occ_ff, occ_in;
   logic                        strobe_ff;
   logic [bfps_pkg::STAT_W-1:0] status_ff, status_in;
   logic                        rd_ok_ff, rd_ok_in;
   logic [bfps_pkg::CNT_W-1:0]  cnt_occ;

   // occupancy extended to the count width for range compares
   assign cnt_occ = bfps_pkg::CNT_W'(occ_ff);

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in = occ_ff;
      status_in = bfps_pkg::ST_OK;
      rd_ok_in = 1'b0;
      mem_ctrl.wr_en = 1'b0;
      mem_ctrl.wr_addr = tail_ff;
      mem_ctrl.wr_data = req.push_byte;
      mem_ctrl.rd_en = 1'b0;
      mem_ctrl.rd_addr = bfps_pkg::ring_add(head_ff, req.count_or_offset);
      if (accept) begin
         unique case (req.kind)
            bfps_pkg::OP_PUSH: begin
               if (occ_ff == bfps_pkg::OCC_FULL) begin
                  status_in = bfps_pkg::ST_FULL;
               end else begin
                  mem_ctrl.wr_en = 1'b1;
                  tail_in = bfps_pkg::ring_add(tail_ff, bfps_pkg::CNT_W'(1));
                  occ_in = occ_ff + bfps_pkg::OCC_W'(1);
               end
            end
            bfps_pkg::OP_POP: begin
               mem_ctrl.rd_addr = head_ff;
               if (occ_ff == '0) begin
                  status_in = bfps_pkg::ST_RANGE;
               end else begin
                  mem_ctrl.rd_en = 1'b1;
                  rd_ok_in = 1'b1;
                  head_in = bfps_pkg::ring_add(head_ff, bfps_pkg::CNT_W'(1));
                  occ_in = occ_ff - bfps_pkg::OCC_W'(1);
               end
            end
            bfps_pkg::OP_PEEK: begin
               if (req.count_or_offset >= cnt_occ) begin
                  status_in = bfps_pkg::ST_RANGE;
               end else begin
                  mem_ctrl.rd_en = 1'b1;
                  rd_ok_in = 1'b1;
               end
            end
            bfps_pkg::OP_SKIP: begin
               if (req.count_or_offset > cnt_occ) begin
                  status_in = bfps_pkg::ST_RANGE;
               end else begin
                  head_in = bfps_pkg::ring_add(head_ff, req.count_or_offset);
                  occ_in = bfps_pkg::OCC_W'(cnt_occ - req.count_or_offset);
               end
            end
            bfps_pkg::OP_CLEAR: begin
               head_in = '0;
               tail_in = '0;
               occ_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff <= occ_in;
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rd_ok_ff <= rd_ok_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp.read_byte = rd_ok_ff ? rd_q : '0;
   assign rsp.status = status_ff;
   assign rsp.fill_level = occ_ff;
   assign rsp.not_empty = (occ_ff != '0);

endmodule

/* sv/byte_fifo_with_peek_skip.sv */
// Top level of the byte FIFO with peek and skip.
// Depends on bfps_pkg, bfps_ctrl and bfps_store.
//
// Usage:
//   A request (push, pop, peek, skip or clear) is taken at a rising clock edge
//   with start high and busy low. busy is always low: one request is taken
//   every cycle, for a sustained rate of one request per clock.
//   Each request gives one response on rsp_data, marked by rsp_strobe for one
//   cycle, in the cycle right after the request was taken.
//   Pointer and occupancy update at the accepting edge; the byte store is
//   read through its single registered read port in that same edge, so the
//   next request already sees the new state.
//   The receiver cannot stall: every response must be taken when strobed.
//   Reset (synchronous, active high) empties the FIFO and drops any pending
//   response. Stored bytes are not cleared; only bytes within the fill level
//   are ever read.
module byte_fifo_with_peek_skip (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bfps_pkg::req_type req_data,
   output logic              rsp_strobe,
   output bfps_pkg::rsp_type rsp_data
);

   bfps_pkg::mem_ctrl_type      mem_ctrl;
   logic [bfps_pkg::BYTE_W-1:0] rd_q;
   logic                        accept;

   assign busy = 1'b0;
   assign accept = start && !busy;

   bfps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .rd_q       (rd_q),
      .mem_ctrl   (mem_ctrl),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

   bfps_store u_store (
      .clock    (clock),
      .mem_ctrl (mem_ctrl),
      .rd_q     (rd_q)
   );

endmodule

/* sv/bfps_checker.sv */
// Port-level checks for the byte FIFO with peek and skip, bound to the top level.
// Depends on bfps_pkg and byte_fifo_with_peek_skip.
module bfps_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input bfps_pkg::rsp_type rsp_data
);

   // each accepted request gets its response in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (!reset && start && !busy) |=> rsp_strobe)
      else $error("response missing after request");

   // no response without a request
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("response without request");

   a_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.not_empty == (rsp_data.fill_level != '0)))
      else $error("not_empty disagrees with fill level");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != bfps_pkg::ST_OK) |-> (rsp_data.read_byte == '0))
      else $error("failed request returned a byte");

   a_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == bfps_pkg::ST_FULL)
         |-> (rsp_data.fill_level == bfps_pkg::OCC_FULL))
      else $error("push dropped while not full");

endmodule

bind byte_fifo_with_peek_skip bfps_checker u_bfps_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

/* dv/tb_byte_fifo_with_peek_skip.sv */
// Testbench for byte_fifo_with_peek_skip: directed and random push/pop/peek/skip/clear requests,
// each response checked against a local ring-buffer predictor.
// Depends on bfps_pkg and byte_fifo_with_peek_skip.
module tb_byte_fifo_with_peek_skip;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [bfps_pkg::KIND_W-1:0] OP_UNUSED_LO = bfps_pkg::OP_CLEAR + 3'd1;
   localparam logic [bfps_pkg::KIND_W-1:0] OP_UNUSED_MID = 3'd6;
   localparam logic [bfps_pkg::KIND_W-1:0] OP_UNUSED_HI = 3'd7;
   localparam logic [bfps_pkg::CNT_W-1:0] CNT_MAX = '1;

   typedef enum int {MIX_BALANCED, MIX_FILLING, MIX_DRAINING} traffic_mix_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   bfps_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   bfps_pkg::rsp_type rsp_data;

   // predictor state
   logic [bfps_pkg::BYTE_W-1:0] model_store [bfps_pkg::DEPTH];
   logic [bfps_pkg::IDX_W-1:0]  model_head = '0;
   logic [bfps_pkg::IDX_W-1:0]  model_tail = '0;
   logic [bfps_pkg::OCC_W-1:0]  model_occ = '0;

   bfps_pkg::rsp_type pending_rsp_q[$];
   int                error_count = 0;
   int                cycle_count = 0;

   byte_fifo_with_peek_skip DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_byte_fifo_with_peek_skip failed");
         $finish;
      end
   end

   function automatic logic [bfps_pkg::IDX_W-1:0] advance_index(input int pos, input int n);
      int s;
      s = pos + n;
      if (s >= bfps_pkg::DEPTH) begin
         s = s - bfps_pkg::DEPTH;
      end
      return s[bfps_pkg::IDX_W-1:0];
   endfunction

   function automatic bfps_pkg::rsp_type apply_fifo_op(input bfps_pkg::req_type r);
      bfps_pkg::rsp_type o;
      o = '0;
      o.status = bfps_pkg::ST_OK;
      case (r.kind)
         bfps_pkg::OP_PUSH: begin
            if (model_occ >= bfps_pkg::OCC_W'(bfps_pkg::DEPTH)) begin
               o.status = bfps_pkg::ST_FULL;
            end else begin
               model_store[model_tail] = r.push_byte;
               model_tail = advance_index(model_tail, 1);
               model_occ = model_occ + bfps_pkg::OCC_W'(1);
            end
         end
         bfps_pkg::OP_POP: begin
            if (model_occ == '0) begin
               o.status = bfps_pkg::ST_RANGE;
            end else begin
               o.read_byte = model_store[model_head];
               model_head = advance_index(model_head, 1);
               model_occ = model_occ - bfps_pkg::OCC_W'(1);
            end
         end
         bfps_pkg::OP_PEEK: begin
            if (r.count_or_offset >= model_occ) begin
               o.status = bfps_pkg::ST_RANGE;
            end else begin
               o.read_byte = model_store[advance_index(model_head, r.count_or_offset)];
            end
         end
         bfps_pkg::OP_SKIP: begin
            if (r.count_or_offset > model_occ) begin
               o.status = bfps_pkg::ST_RANGE;
            end else begin
               model_head = advance_index(model_head, r.count_or_offset);
               model_occ = model_occ - bfps_pkg::OCC_W'(r.count_or_offset);
            end
         end
         bfps_pkg::OP_CLEAR: begin
            model_head = '0;
            model_tail = '0;
            model_occ = '0;
         end
         default: ;
      endcase
      o.fill_level = model_occ;
      o.not_empty = (model_occ != '0);
      return o;
   endfunction

   // response checker
   always @(posedge clock) begin
      bfps_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.read_byte !== want.read_byte) begin
               $display("%0t: read_byte expected %0d actual %0d", $time, want.read_byte,
                        rsp_data.read_byte);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_data.status);
               error_count++;
            end
            if (rsp_data.fill_level !== want.fill_level) begin
               $display("%0t: fill_level expected %0d actual %0d", $time, want.fill_level,
                        rsp_data.fill_level);
               error_count++;
            end
            if (rsp_data.not_empty !== want.not_empty) begin
               $display("%0t: not_empty expected %0d actual %0d", $time, want.not_empty,
                        rsp_data.not_empty);
               error_count++;
            end
         end
      end
   end

   // called at a rising edge; returns at the edge that took the request
   task automatic send_req(input bfps_pkg::req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pending_rsp_q.push_back(apply_fifo_op(r));
   endtask

   task automatic send_op(input logic [bfps_pkg::KIND_W-1:0] kind,
                          input logic [bfps_pkg::BYTE_W-1:0] pbyte,
                          input logic [bfps_pkg::CNT_W-1:0] cnt);
      bfps_pkg::req_type r;
      r.kind = kind;
      r.push_byte = pbyte;
      r.count_or_offset = cnt;
      send_req(r);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic test_empty_fifo();
      send_op(bfps_pkg::OP_POP, 8'h00, '0);
      send_op(bfps_pkg::OP_PEEK, 8'hFF, '0);
      send_op(bfps_pkg::OP_SKIP, 8'h00, '0);
      send_op(bfps_pkg::OP_SKIP, 8'h00, 9'd1);
      send_op(OP_UNUSED_LO, 8'hFF, CNT_MAX);
      send_op(OP_UNUSED_MID, 8'h5A, 9'd256);
      send_op(OP_UNUSED_HI, 8'hA5, 9'd255);
      send_op(bfps_pkg::OP_CLEAR, 8'h00, '0);
   endtask

   task automatic test_push_pop_edges();
      send_op(bfps_pkg::OP_PUSH, 8'h00, CNT_MAX);
      send_op(bfps_pkg::OP_PUSH, 8'hFF, '0);
      send_op(bfps_pkg::OP_PEEK, 8'h00, 9'd0);
      send_op(bfps_pkg::OP_PEEK, 8'h00, 9'd1);
      send_op(bfps_pkg::OP_PEEK, 8'h00, 9'd2);
      send_op(bfps_pkg::OP_PEEK, 8'h00, 9'd256);
      send_op(bfps_pkg::OP_PEEK, 8'h00, CNT_MAX);
      send_op(bfps_pkg::OP_SKIP, 8'h00, 9'd3);
      send_op(bfps_pkg::OP_POP, 8'h00, '0);
      send_op(bfps_pkg::OP_SKIP, 8'h00, 9'd0);
      send_op(bfps_pkg::OP_SKIP, 8'h00, 9'd1);
      send_op(bfps_pkg::OP_PUSH, 8'h81, '0);
      send_op(bfps_pkg::OP_PUSH, 8'h7E, '0);
      send_op(bfps_pkg::OP_CLEAR, 8'hFF, CNT_MAX);
      send_op(bfps_pkg::OP_POP, 8'h00, '0);
   endtask

   task automatic test_full_and_wrap();
      repeat (5) send_op(bfps_pkg::OP_PUSH, 8'($urandom), 9'($urandom));
      repeat (3) send_op(bfps_pkg::OP_POP, 8'($urandom), 9'($urandom));
      while (model_occ < bfps_pkg::OCC_W'(bfps_pkg::DEPTH)) begin
         send_op(bfps_pkg::OP_PUSH, 8'($urandom), 9'($urandom));
      end
      send_op(bfps_pkg::OP_PUSH, 8'h00, '0);
      send_op(bfps_pkg::OP_PUSH, 8'hFF, CNT_MAX);
      send_op(bfps_pkg::OP_PEEK, 8'h00, 9'd255);
      send_op(bfps_pkg::OP_PEEK, 8'h00, 9'd256);
      send_op(bfps_pkg::OP_POP, 8'h00, '0);
      send_op(bfps_pkg::OP_PUSH, 8'hC3, '0);
      send_op(bfps_pkg::OP_SKIP, 8'h00, 9'd257);
      send_op(bfps_pkg::OP_SKIP, 8'h00, 9'd256);
      send_op(bfps_pkg::OP_POP, 8'h00, '0);
   endtask

   task automatic test_pause_until_drained();
      repeat (4) send_op(bfps_pkg::OP_PUSH, 8'($urandom), 9'($urandom));
      wait_drained();
      send_op(bfps_pkg::OP_PEEK, 8'h00, 9'd3);
      send_op(bfps_pkg::OP_POP, 8'h00, '0);
      wait_drained();
      send_op(bfps_pkg::OP_SKIP, 8'h00, 9'd3);
   endtask

   function automatic bfps_pkg::req_type pick_request(input traffic_mix_type mix);
      bfps_pkg::req_type r;
      int                roll;
      int                push_pct;
      int                occ;
      occ = model_occ;
      r.push_byte = 8'($urandom);
      r.count_or_offset = 9'($urandom);
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILLING:  push_pct = 80;
         MIX_DRAINING: push_pct = 20;
         default:      push_pct = 45;
      endcase
      if (roll < push_pct) begin
         r.kind = bfps_pkg::OP_PUSH;
      end else if (roll < push_pct + (100 - push_pct) * 35 / 100) begin
         r.kind = bfps_pkg::OP_POP;
      end else if (roll < push_pct + (100 - push_pct) * 70 / 100) begin
         r.kind = bfps_pkg::OP_PEEK;
         if ($urandom_range(0, 9) < 8) begin
            r.count_or_offset = 9'($urandom_range(0, occ));
         end
      end else if (roll < push_pct + (100 - push_pct) * 92 / 100) begin
         r.kind = bfps_pkg::OP_SKIP;
         case ($urandom_range(0, 9))
            0:       r.count_or_offset = 9'(occ);
            1:       r.count_or_offset = 9'(occ + 1);
            2:       ;
            default: r.count_or_offset = 9'($urandom_range(0, (occ < 8) ? occ + 1 : 8));
         endcase
      end else if (roll < 99) begin
         r.kind = ($urandom_range(0, 3) == 0) ? bfps_pkg::OP_CLEAR
                                              : 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else begin
         r.kind = bfps_pkg::OP_CLEAR;
      end
      return r;
   endfunction

   task automatic test_random_traffic(input int count, input bit allow_idle);
      traffic_mix_type mix;
      int              seg_left;
      bit              idle_on;
      seg_left = 0;
      mix = MIX_BALANCED;
      idle_on = 1'b0;
      repeat (count) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 120);
            mix = traffic_mix_type'($urandom_range(MIX_BALANCED, MIX_DRAINING));
            idle_on = allow_idle && ($urandom_range(0, 2) != 0);
         end
         seg_left--;
         if (idle_on && $urandom_range(0, 5) == 0) begin
            pause_sender($urandom_range(1, 13));
         end
         send_req(pick_request(mix));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_fifo();
      test_push_pop_edges();
      test_full_and_wrap();
      test_pause_until_drained();
      test_random_traffic(1000, 1'b1);
      test_random_traffic(150, 1'b0);
      wait_drained();
      repeat (3) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_byte_fifo_with_peek_skip passed");
      end else begin
         $display("tb_byte_fifo_with_peek_skip failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/bfps_pkg.sv
sv/bfps_store.sv
sv/bfps_ctrl.sv
sv/byte_fifo_with_peek_skip.sv
sv/bfps_checker.sv
dv/tb_byte_fifo_with_peek_skip.sv
